@@ src/iwj_pkg.sv @@
`default_nettype none
package iwj_pkg;

  localparam int CHROM_W     = 8;
  localparam int POS_W       = 31;
  localparam int LOAD_IDX_W  = 12;
  localparam int TAG_W       = 16;
  localparam int REF_IDX_W   = 12;
  localparam int CUT_W       = 31;

  localparam int DEF_REF_DEPTH = 4096;
  localparam int DEF_MAX_HITS  = 63;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
  } ref_entry_t;

  localparam int ENTRY_W = $bits(ref_entry_t);

endpackage
`default_nettype wire

@@ src/iwj_if.sv @@
`default_nettype none
interface iwj_item_if
  import iwj_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [LOAD_IDX_W-1:0] load_index;
  logic [CHROM_W-1:0]    chrom_id;
  logic [POS_W-1:0]      start_pos;
  logic [POS_W-1:0]      end_pos;
  logic                  minus_strand;
  logic [TAG_W-1:0]      query_tag;

  modport source (output valid, func, load_index, chrom_id, start_pos, end_pos,
                  minus_strand, query_tag, input ready);
  modport sink (input valid, func, load_index, chrom_id, start_pos, end_pos,
                minus_strand, query_tag, output ready);
endinterface

interface iwj_result_if
  import iwj_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [TAG_W-1:0]     tag_out;
  logic [REF_IDX_W-1:0] ref_index;
  logic [POS_W-1:0]     distance;
  logic                 hit;
  logic                 overflow;
  logic                 last;

  modport source (output valid, tag_out, ref_index, distance, hit, overflow, last,
                  input ready);
  modport sink (input valid, tag_out, ref_index, distance, hit, overflow, last,
                output ready);
endinterface

interface iwj_cfg_if
  import iwj_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CUT_W-1:0] cut_distance;

  modport source (output valid, cut_distance, input ready);
  modport sink (input valid, cut_distance, output ready);
endinterface
`default_nettype wire

@@ src/interval_window_join_core.sv @@
// Interval window join core.
// Channels: item (sink) carries load and query beats, result (source) carries
// result beats, cfg (sink) writes cut_distance and is always ready.
// A load beat (func = 0) with load_index below REF_DEPTH writes one reference
// slot, sets the reference count to load_index + 1 and rewinds the sweep pointer.
// A query beat (func = 1) walks the reference table, which sits in one
// single-port-read RAM with a registered read port. The query steps are:
//   take the beat and issue the first read,
//   skip entries while moving to the query's chromosome,
//   check the chromosome at the sweep pointer,
//   scan the entries in the window,
//   send the terminator beat.
// Item ready is high only between queries. Each hit, up to MAX_HITS, is one
// result beat; further hits set the overflow flag. The query always ends
// with a beat that has last = 1 and the overflow flag.
// A stalled receiver holds the result register and freezes the scan when a
// further hit needs it; the next item is taken while the terminator still waits there.
// Synchronous reset clears the count, the sweep pointer, cut_distance and
// result valid; table contents are undefined until loaded.
`default_nettype none
module interval_window_join_core
  import iwj_pkg::*;
#(
  parameter int REF_DEPTH = DEF_REF_DEPTH,
  parameter int MAX_HITS  = DEF_MAX_HITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  iwj_item_if.sink      item,
  iwj_result_if.source  result,
  iwj_cfg_if.sink       cfg
);

  localparam int AW = $clog2(REF_DEPTH);

  logic [CUT_W-1:0] cut;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ref_entry_t       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  ref_entry_t       rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut <= '0;
    end else if (cfg.valid) begin
      cut <= cfg.cut_distance;
    end
  end

  iwj_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (REF_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  iwj_scan #(
    .REF_DEPTH (REF_DEPTH),
    .MAX_HITS  (MAX_HITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .cut     (cut),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

@@ src/iwj_ram.sv @@
`default_nettype none
module iwj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/iwj_scan.sv @@
`default_nettype none
module iwj_scan
  import iwj_pkg::*;
#(
  parameter int REF_DEPTH = DEF_REF_DEPTH,
  parameter int MAX_HITS  = DEF_MAX_HITS,
  localparam int AW = $clog2(REF_DEPTH),
  localparam int CW = AW + 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  iwj_item_if.sink          item,
  iwj_result_if.source      result,
  input  wire logic [CUT_W-1:0] cut,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output ref_entry_t        wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  wire ref_entry_t   rd_data
);

  localparam int HW = $clog2(MAX_HITS + 1);

  typedef enum logic [1:0] {IDLE, CHROM, SCAN, TERM} state_t;

  state_t               state;
  logic [CW-1:0]        ref_count;
  logic [CW-1:0]        sweep;
  logic [AW-1:0]        idx;
  logic [HW-1:0]        nhits;
  logic                 ovf;
  logic [CHROM_W-1:0]   qchr;
  logic [POS_W-1:0]     qs;
  logic [POS_W-1:0]     qe;
  logic                 qminus;
  logic [TAG_W-1:0]     qtag;

  logic                 out_valid;
  logic [TAG_W-1:0]     out_tag;
  logic [REF_IDX_W-1:0] out_index;
  logic [POS_W-1:0]     out_dist;
  logic                 out_hit;
  logic                 out_ovf;
  logic                 out_last;

  logic                 beat;
  logic                 slot_ok;
  logic                 out_free;
  logic                 out_load;
  logic [POS_W:0]       qe_cut;
  logic [POS_W:0]       re_cut;
  logic                 stop;
  logic                 skip;
  logic                 overlap;
  logic                 found;
  logic [POS_W-1:0]     hit_dist;
  logic                 room;
  logic                 stall;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        sweep_inc;
  logic                 more;
  logic                 advance;

  assign item.ready = (state == IDLE);
  assign beat       = item.valid && item.ready;
  assign slot_ok    = 32'(item.load_index) < 32'(REF_DEPTH);

  assign wr_en   = beat && (item.func == FUNC_LOAD) && slot_ok;
  assign wr_addr = AW'(item.load_index);
  assign wr_data = '{chrom: item.chrom_id, start_pos: item.start_pos,
                     end_pos: item.end_pos};

  assign out_free  = !out_valid || result.ready;
  assign qe_cut    = {1'b0, qe} + {1'b0, cut};
  assign re_cut    = {1'b0, rd_data.end_pos} + {1'b0, cut};
  assign stop      = (rd_data.chrom != qchr) || (qe_cut < {1'b0, rd_data.start_pos});
  assign skip      = {1'b0, qs} > re_cut;
  assign overlap   = (qe > rd_data.start_pos) && (qs < rd_data.end_pos);
  assign found     = !skip && (overlap || (!qminus && (qe < rd_data.start_pos)) ||
                               (qminus && (qs > rd_data.end_pos)));
  assign room      = nhits < HW'(MAX_HITS);
  assign stall     = found && room && !out_free;
  assign idx_inc   = {1'b0, idx} + CW'(1);
  assign sweep_inc = sweep + CW'(1);
  assign more      = idx_inc < ref_count;
  assign advance   = (sweep_inc < ref_count) && (qchr > rd_data.chrom);
  assign out_load  = ((state == SCAN) && !stop && !stall && found && room) ||
                     ((state == TERM) && out_free);

  always_comb begin
    if (overlap) begin
      hit_dist = '0;
    end else if (qminus) begin
      hit_dist = qs - rd_data.end_pos;
    end else begin
      hit_dist = rd_data.start_pos - qe;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sweep[AW-1:0];
    unique case (state)
      IDLE: begin
        rd_en = beat && (item.func == FUNC_QUERY) && (sweep < ref_count);
      end
      CHROM: begin
        rd_en   = advance;
        rd_addr = sweep_inc[AW-1:0];
      end
      SCAN: begin
        rd_en   = !stop && !stall && more;
        rd_addr = idx_inc[AW-1:0];
      end
      TERM: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ref_count <= '0;
      sweep     <= '0;
      out_valid <= 1'b0;
      nhits     <= '0;
      ovf       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (beat && (item.func == FUNC_LOAD)) begin
            if (slot_ok) begin
              ref_count <= CW'(32'(item.load_index) + 32'd1);
              sweep     <= '0;
            end
          end else if (beat) begin
            qchr   <= item.chrom_id;
            qs     <= item.start_pos;
            qe     <= item.end_pos;
            qminus <= item.minus_strand;
            qtag   <= item.query_tag;
            nhits  <= '0;
            ovf    <= 1'b0;
            state  <= (sweep < ref_count) ? CHROM : TERM;
          end
        end
        CHROM: begin
          if (advance) begin
            sweep <= sweep_inc;
          end else if (qchr < rd_data.chrom) begin
            state <= TERM;
          end else begin
            idx   <= sweep[AW-1:0];
            state <= SCAN;
          end
        end
        SCAN: begin
          if (stop) begin
            state <= TERM;
          end else if (!stall) begin
            if (found && room) begin
              out_tag   <= qtag;
              out_index <= REF_IDX_W'(idx);
              out_dist  <= hit_dist;
              out_hit   <= 1'b1;
              out_ovf   <= 1'b0;
              out_last  <= 1'b0;
              nhits     <= nhits + HW'(1);
            end else if (found) begin
              ovf <= 1'b1;
            end
            if (skip && (sweep == {1'b0, idx})) begin
              sweep <= sweep_inc;
            end
            if (more) begin
              idx <= idx_inc[AW-1:0];
            end else begin
              state <= TERM;
            end
          end
        end
        TERM: begin
          if (out_free) begin
            out_tag   <= qtag;
            out_index <= '0;
            out_dist  <= '0;
            out_hit   <= 1'b0;
            out_ovf   <= ovf;
            out_last  <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign result.valid     = out_valid;
  assign result.tag_out   = out_tag;
  assign result.ref_index = out_index;
  assign result.distance  = out_dist;
  assign result.hit       = out_hit;
  assign result.overflow  = out_ovf;
  assign result.last      = out_last;

endmodule
`default_nettype wire

@@ src/iwj_checker.sv @@
`default_nettype none
module iwj_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic item_valid,
  input wire logic item_ready,
  input wire logic item_func,
  input wire logic result_valid,
  input wire logic result_ready,
  input wire logic result_hit,
  input wire logic result_overflow,
  input wire logic result_last
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_last))
    else $error("result beat dropped while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_func |=> !item_ready)
    else $error("item taken during a query");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_hit_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_hit |-> !result_last && !result_overflow)
    else $error("hit beat marked as terminator");

endmodule

bind interval_window_join_core iwj_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_func       (item.func),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_hit      (result.hit),
  .result_overflow (result.overflow),
  .result_last     (result.last)
);
`default_nettype wire
